// ----- design/bitmap_first_free_finder_macros.svh -----
// Assertion macros used by the bitmap first-free finder design file.
`ifndef BITMAP_FIRST_FREE_FINDER_MACROS_SVH
`define BITMAP_FIRST_FREE_FINDER_MACROS_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define BFF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that cons holds in the cycle after ante holds.
`define BFF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/bff_pkg.sv -----
// Package with the field widths, mode codes and register map of the bitmap finder.
package bff_pkg;

  // Fixed widths of the request, result and register fields.
  localparam int SIZE_W = 13;
  localparam int IDX_W  = 12;
  localparam int MODE_W = 2;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Request mode codes.
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIND  = 2'd2;

  // Register index, taken from address bit 2 (registers are 4 bytes apart).
  localparam logic REG_BITS_IN_USE = 1'b0;

endpackage

// ----- design/bff_if.sv -----
// Request and response channel interfaces of the bitmap finder.
interface bff_req_if;
  import bff_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [IDX_W-1:0]  bit_index;
  logic              bit_value;

  modport source (output valid, mode, bit_index, bit_value, input ready);
  modport sink (input valid, mode, bit_index, bit_value, output ready);
endinterface

interface bff_rsp_if;
  import bff_pkg::*;
  logic              valid;
  logic              ready;
  logic              bit_read;
  logic [SIZE_W-1:0] free_index;
  logic              index_error;

  modport source (output valid, bit_read, free_index, index_error, input ready);
  modport sink (input valid, bit_read, free_index, index_error, output ready);
endinterface

// ----- design/bitmap_first_free_finder.sv -----
// Bitmap allocator: bit read, bit write and find-lowest-clear over a word memory.
// After a request transfer, a read or write passes through the access state, a find
// scans the words in the scan state, and an index error or an unused mode goes to
// the hold state; from hold the result moves to the output register when it is free.
// No new request is taken until then; the single memory read port, one word a cycle, sets the find rate.
// Reset (rst, synchronous) starts a clearing pass over all NUM_WORDS words (128 by
// default) that zeroes the memory; no request is taken until it ends.
`include "bitmap_first_free_finder_macros.svh"

module bitmap_first_free_finder #(
  parameter int MAX_BITS  = 4096,
  parameter int WORD_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bff_pkg::ADDR_W-1:0] paddr,
  input  logic [bff_pkg::DATA_W-1:0] pwdata,
  output logic [bff_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  bff_req_if.sink                    req,
  bff_rsp_if.source                  rsp
);
  import bff_pkg::*;

  localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BI_W      = $clog2(WORD_BITS);
  localparam int BASE_W    = $clog2((1 << SIZE_W) + WORD_BITS);
  localparam logic [AW-1:0] LAST_WORD = AW'(NUM_WORDS - 1);
  localparam logic [SIZE_W-1:0] SIZE_CAP =
    (MAX_BITS >= (1 << SIZE_W)) ? {SIZE_W{1'b1}} : SIZE_W'(MAX_BITS);

  // Word index by reciprocal multiply; exact for every IDX_W-bit index.
  localparam int DIV_SH = IDX_W + $clog2(WORD_BITS);
  localparam int MW     = DIV_SH + 1;
  localparam int PW     = IDX_W + MW;
  localparam logic [MW-1:0] DIV_M = MW'(((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS);
  localparam logic [IDX_W-1:0] WB_IDX = IDX_W'(WORD_BITS);
  localparam logic [BASE_W-1:0] WB_BASE = BASE_W'(WORD_BITS);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_ACCESS = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_HOLD   = 5'b10000
  } state_t;

  state_t              state;
  logic [AW-1:0]       clr_addr;
  logic [SIZE_W-1:0]   bits_in_use;
  logic [SIZE_W-1:0]   size;
  logic [IDX_W-1:0]    req_index;
  logic [IDX_W-1:0]    req_word;
  logic                req_write;
  logic                req_value;
  logic [AW-1:0]       word_addr;
  logic [BASE_W-1:0]   scan_base;
  logic                res_bit_read;
  logic [SIZE_W-1:0]   res_free_index;
  logic                res_index_error;
  logic                rsp_valid;
  logic                rsp_bit_read;
  logic [SIZE_W-1:0]   rsp_free_index;
  logic                rsp_index_error;

  // Word memory and its port controls.
  logic [WORD_BITS-1:0] bit_words [NUM_WORDS];
  logic [WORD_BITS-1:0] mem_rdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;

  logic                 req_xfer;
  logic                 cfg_write;
  logic                 is_rw;
  logic                 out_of_range;
  logic [PW-1:0]        div_prod;
  logic [IDX_W-1:0]     div_word;
  logic [BI_W-1:0]      bit_pos;
  logic [WORD_BITS-1:0] bit_mask;
  logic [WORD_BITS-1:0] new_word;
  logic                 zero_found;
  logic [BI_W-1:0]      zero_pos;
  logic [BASE_W-1:0]    found_pos;
  logic [BASE_W-1:0]    next_base;
  logic                 more_words;
  logic                 slot_free;

  // Configuration port: writes complete in the access phase, reads are combinational.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_BITS_IN_USE) ? DATA_W'(bits_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_in_use <= '0;
      size        <= '0;
    end else if (cfg_write && (paddr[2] == REG_BITS_IN_USE)) begin
      bits_in_use <= pwdata[SIZE_W-1:0];
      size        <= (pwdata[SIZE_W-1:0] > SIZE_CAP) ? SIZE_CAP : pwdata[SIZE_W-1:0];
    end
  end

  // Request decode and word index of the requested bit.
  assign req.ready    = (state == ST_IDLE);
  assign req_xfer     = req.valid && req.ready;
  assign is_rw        = (req.mode == MODE_READ) || (req.mode == MODE_WRITE);
  assign out_of_range = ({1'b0, req.bit_index} >= size);
  assign div_prod     = PW'(req.bit_index) * PW'(DIV_M);
  assign div_word     = IDX_W'(div_prod >> DIV_SH);

  // Bit position within the fetched word and the modified word.
  assign bit_pos  = BI_W'(req_index - (req_word * WB_IDX));
  assign bit_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_pos;
  assign new_word = req_value ? (mem_rdata | bit_mask) : (mem_rdata & ~bit_mask);

  // Lowest clear bit of the word under examination.
  always_comb begin
    zero_found = 1'b0;
    zero_pos   = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (!mem_rdata[j]) begin
        zero_found = 1'b1;
        zero_pos   = BI_W'(j);
      end
    end
  end

  assign found_pos  = scan_base + BASE_W'(zero_pos);
  assign next_base  = scan_base + WB_BASE;
  assign more_words = (next_base < BASE_W'(size));
  assign slot_free  = !rsp_valid || rsp.ready;

  // Memory port selection per state.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      ST_IDLE: begin
        if (req_xfer && is_rw && !out_of_range) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(div_word);
        end else if (req_xfer && (req.mode == MODE_FIND) && (size != '0)) begin
          mem_re = 1'b1;
        end
      end
      ST_ACCESS: begin
        if (req_write) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(req_word);
          mem_wdata = new_word;
        end
      end
      ST_SCAN: begin
        if (!zero_found && more_words) begin
          mem_re    = 1'b1;
          mem_raddr = word_addr + 1'b1;
        end
      end
      ST_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bit_words[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= bit_words[mem_raddr];
    end
  end

  // Control sequencer: clearing pass, request intake, access, scan, result hold.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_WORD) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_xfer) begin
            if (is_rw && !out_of_range) begin
              state <= ST_ACCESS;
            end else if ((req.mode == MODE_FIND) && (size != '0)) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_HOLD;
            end
          end
        end
        ST_ACCESS: begin
          state <= ST_HOLD;
        end
        ST_SCAN: begin
          if (zero_found || !more_words) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Request capture, scan position and result payload.
  always_ff @(posedge clk) begin
    unique case (state) inside
      ST_IDLE: begin
        if (req_xfer) begin
          req_index       <= req.bit_index;
          req_word        <= div_word;
          req_write       <= (req.mode == MODE_WRITE);
          req_value       <= req.bit_value;
          word_addr       <= '0;
          scan_base       <= '0;
          res_bit_read    <= 1'b0;
          res_free_index  <= '0;
          res_index_error <= is_rw && out_of_range;
        end
      end
      ST_ACCESS: begin
        res_bit_read <= !req_write && mem_rdata[bit_pos];
      end
      ST_SCAN: begin
        if (zero_found) begin
          res_free_index <= (found_pos >= BASE_W'(size)) ? size : SIZE_W'(found_pos);
        end else if (!more_words) begin
          res_free_index <= size;
        end else begin
          word_addr <= word_addr + 1'b1;
          scan_base <= next_base;
        end
      end
      ST_CLEAR, ST_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  // Output register: a finished result waits here while the next request runs.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == ST_HOLD) && slot_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_HOLD) && slot_free) begin
      rsp_bit_read    <= res_bit_read;
      rsp_free_index  <= res_free_index;
      rsp_index_error <= res_index_error;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.bit_read    = rsp_bit_read;
  assign rsp.free_index  = rsp_free_index;
  assign rsp.index_error = rsp_index_error;

  // The memory is written only by the clearing pass and by a bit write.
  `BFF_ASSERT_SAME(a_write_source, mem_we, (state == ST_CLEAR) || (state == ST_ACCESS), "memory written outside clear or access")
  // The scan never walks past the last memory word.
  `BFF_ASSERT_SAME(a_scan_range, state == ST_SCAN, word_addr <= LAST_WORD, "scan address beyond memory")
  // A new result is only loaded from the hold state.
  `BFF_ASSERT_SAME(a_rsp_source, $rose(rsp_valid), $past(state) == ST_HOLD, "result loaded outside hold")
  // A find result never exceeds the size in use.
  `BFF_ASSERT_SAME(a_free_bound, rsp_valid, rsp_free_index <= size, "free index beyond size in use")
  // An index error carries no other result.
  `BFF_ASSERT_SAME(a_error_clean, rsp_valid && rsp_index_error, !rsp_bit_read && (rsp_free_index == '0), "error result with payload")
  // A bit read or write is followed by the result hold.
  `BFF_ASSERT_NEXT(a_access_hold, state == ST_ACCESS, state == ST_HOLD, "access not followed by hold")

endmodule
